[rtl/core/ppb_pkg.sv]
// Shared types, constants and helpers for the perspective projection box pipeline.
package ppb_pkg;

    // Coefficient store and pipeline shape
    localparam int NUM_COEF   = 12;
    localparam int DOT_STAGES = 3;
    localparam int DIV_ITERS  = 16;
    localparam int DIV_STAGES = DIV_ITERS + 1;
    localparam int MAP_STAGES = 5;
    localparam int NUM_STAGES = DOT_STAGES + DIV_STAGES + MAP_STAGES;

    // Box aspect factor 0.526515151552 in unsigned 0.32 format
    localparam logic [31:0] WIDTH_K = 32'd2261365357;

    typedef enum logic {
        KIND_LOAD    = 1'b0,
        KIND_PROJECT = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        CFG_SCREEN_WIDTH  = 2'd0,
        CFG_SCREEN_HEIGHT = 2'd1,
        CFG_FIRST_OFFSET  = 2'd2,
        CFG_SECOND_OFFSET = 2'd3
    } cfg_idx_t;

    // Clip-space values: w and the four numerators (x, y, first row, second row)
    typedef struct packed {
        logic             invis;
        logic [31:0]      w;
        logic [3:0][31:0] num;
    } clip_t;

    // Divider result per lane: magnitude, overflow and sign
    typedef struct packed {
        logic             invis;
        logic [3:0]       neg;
        logic [3:0]       ovf;
        logic [3:0][31:0] quo;
    } quo_t;

    // Saturate a wide signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [79:0] v);
        if (v > 80'sh7FFFFFFF) begin
            return 32'sh7FFFFFFF;
        end
        if (v < -80'sh80000000) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

endpackage

[rtl/core/ppb_dot.sv]
// Coefficient store, input stage and the three clip-space dot products.
module ppb_dot #(
    parameter int FRAC_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [ppb_pkg::DOT_STAGES-1:0]    adv,
    input  logic                              load_we,
    input  logic [3:0]                        coeff_index,
    input  logic signed [31:0]                coeff_value,
    input  logic                              proj_in,
    input  logic signed [31:0]                world_x,
    input  logic signed [31:0]                world_y,
    input  logic signed [31:0]                world_z,
    input  logic signed [31:0]                off_first,
    input  logic signed [31:0]                off_second,
    output logic [ppb_pkg::DOT_STAGES-1:0]    vld,
    output ppb_pkg::clip_t                    clip
);

    logic signed [31:0] coef_reg [ppb_pkg::NUM_COEF];

    logic signed [32:0] zsum1;
    logic signed [32:0] zsum2;
    logic signed [31:0] z1_next;
    logic signed [31:0] z2_next;

    logic signed [31:0] x0_reg, y0_reg, z0_reg, z10_reg, z20_reg;

    logic signed [63:0] prod_next [11];
    logic signed [63:0] prod_reg  [11];
    logic signed [31:0] k0_reg, k1_reg, k2_reg;

    logic signed [63:0] tr [11];
    logic signed [79:0] sum_w, sum_x, sum_y, sum_r1, sum_r2;
    ppb_pkg::clip_t     clip_next;
    ppb_pkg::clip_t     clip_reg;

    logic [ppb_pkg::DOT_STAGES-1:0] vld_reg;
    logic [ppb_pkg::DOT_STAGES-1:0] vld_next;

    // Coefficient store: one write per load item with an index below NUM_COEF
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ppb_pkg::NUM_COEF; i++)
            begin
                coef_reg[i] <= '0;
            end
        end
        else if (load_we && (coeff_index < 4'(ppb_pkg::NUM_COEF)))
        begin
            coef_reg[coeff_index] <= coeff_value;
        end
    end

    // Offset heights, saturated
    always_comb
    begin
        zsum1   = 33'(world_z) + 33'(off_first);
        zsum2   = 33'(world_z) + 33'(off_second);
        z1_next = ppb_pkg::sat32(80'(zsum1));
        z2_next = ppb_pkg::sat32(80'(zsum2));
    end

    // Products, one multiplier each
    always_comb
    begin
        prod_next[0]  = coef_reg[8]  * x0_reg;
        prod_next[1]  = coef_reg[9]  * y0_reg;
        prod_next[2]  = coef_reg[10] * z0_reg;
        prod_next[3]  = coef_reg[0]  * x0_reg;
        prod_next[4]  = coef_reg[1]  * y0_reg;
        prod_next[5]  = coef_reg[2]  * z0_reg;
        prod_next[6]  = coef_reg[4]  * x0_reg;
        prod_next[7]  = coef_reg[5]  * y0_reg;
        prod_next[8]  = coef_reg[6]  * z0_reg;
        prod_next[9]  = coef_reg[6]  * z10_reg;
        prod_next[10] = coef_reg[6]  * z20_reg;
    end

    // Floor-shifted terms summed and saturated
    always_comb
    begin
        for (int i = 0; i < 11; i++)
        begin
            tr[i] = prod_reg[i] >>> FRAC_BITS;
        end
        sum_w  = 80'(tr[0]) + 80'(tr[1]) + 80'(tr[2])  + 80'(k2_reg);
        sum_x  = 80'(tr[3]) + 80'(tr[4]) + 80'(tr[5])  + 80'(k0_reg);
        sum_y  = 80'(tr[6]) + 80'(tr[7]) + 80'(tr[8])  + 80'(k1_reg);
        sum_r1 = 80'(tr[6]) + 80'(tr[7]) + 80'(tr[9])  + 80'(k1_reg);
        sum_r2 = 80'(tr[6]) + 80'(tr[7]) + 80'(tr[10]) + 80'(k1_reg);
        clip_next.w      = ppb_pkg::sat32(sum_w);
        clip_next.num[0] = ppb_pkg::sat32(sum_x);
        clip_next.num[1] = ppb_pkg::sat32(sum_y);
        clip_next.num[2] = ppb_pkg::sat32(sum_r1);
        clip_next.num[3] = ppb_pkg::sat32(sum_r2);
        clip_next.invis  = clip_next.w[31] || (clip_next.w == '0);
    end

    // Valid bits
    always_comb
    begin
        vld_next[0] = adv[0] ? proj_in : vld_reg[0];
        for (int s = 1; s < ppb_pkg::DOT_STAGES; s++)
        begin
            vld_next[s] = adv[s] ? vld_reg[s-1] : vld_reg[s];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // Payload stages
    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            x0_reg  <= world_x;
            y0_reg  <= world_y;
            z0_reg  <= world_z;
            z10_reg <= z1_next;
            z20_reg <= z2_next;
        end
        if (adv[1])
        begin
            prod_reg <= prod_next;
            k0_reg   <= coef_reg[3];
            k1_reg   <= coef_reg[7];
            k2_reg   <= coef_reg[11];
        end
        if (adv[2])
        begin
            clip_reg <= clip_next;
        end
    end

    assign vld  = vld_reg;
    assign clip = clip_reg;

endmodule

[rtl/core/ppb_div.sv]
// Pipelined restoring divider: four numerators scaled by 2^FRAC_BITS over one w.
module ppb_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [ppb_pkg::DIV_STAGES-1:0]    adv,
    input  logic                              in_vld,
    input  ppb_pkg::clip_t                    clip,
    output logic [ppb_pkg::DIV_STAGES-1:0]    vld,
    output ppb_pkg::quo_t                     quo
);

    localparam int NS        = ppb_pkg::DIV_STAGES;
    localparam int STEP_BITS = 32 / ppb_pkg::DIV_ITERS;

    logic [3:0][32:0] rem_reg  [NS];
    logic [3:0][32:0] rem_next [NS];
    logic [3:0][31:0] lo_reg   [NS];
    logic [3:0][31:0] lo_next  [NS];
    logic [3:0][31:0] q_reg    [NS];
    logic [3:0][31:0] q_next   [NS];
    logic [3:0]       ovf_reg  [NS];
    logic [3:0]       ovf_next [NS];
    logic [3:0]       neg_reg  [NS];
    logic [3:0]       neg_next [NS];
    logic [31:0]      w_reg    [NS];
    logic [31:0]      w_next   [NS];
    logic             inv_reg  [NS];
    logic             inv_next [NS];

    logic [NS-1:0] vld_reg;
    logic [NS-1:0] vld_next;

    // Entry stage (magnitude split, overflow check, first remainder),
    // then the iteration stages, STEP_BITS quotient bits each
    always_comb
    begin
        logic [31:0] mag;
        logic [31:0] hi;
        logic [32:0] r;
        logic [31:0] l;
        logic [31:0] q;
        for (int i = 0; i < 4; i++)
        begin
            neg_next[0][i] = clip.num[i][31];
            mag            = clip.num[i][31] ? (32'd0 - clip.num[i]) : clip.num[i];
            hi             = mag >> (32 - FRAC_BITS);
            lo_next[0][i]  = mag << FRAC_BITS;
            ovf_next[0][i] = (hi >= clip.w);
            rem_next[0][i] = {1'b0, hi};
            q_next[0][i]   = '0;
        end
        w_next[0]   = clip.w;
        inv_next[0] = clip.invis;

        for (int s = 1; s < NS; s++)
        begin
            for (int i = 0; i < 4; i++)
            begin
                r = rem_reg[s-1][i];
                l = lo_reg[s-1][i];
                q = q_reg[s-1][i];
                for (int b = 0; b < STEP_BITS; b++)
                begin
                    r = {r[31:0], l[31]};
                    l = l << 1;
                    if (r >= {1'b0, w_reg[s-1]})
                    begin
                        r = r - {1'b0, w_reg[s-1]};
                        q = {q[30:0], 1'b1};
                    end
                    else
                    begin
                        q = {q[30:0], 1'b0};
                    end
                end
                rem_next[s][i] = r;
                lo_next[s][i]  = l;
                q_next[s][i]   = q;
            end
            ovf_next[s] = ovf_reg[s-1];
            neg_next[s] = neg_reg[s-1];
            w_next[s]   = w_reg[s-1];
            inv_next[s] = inv_reg[s-1];
        end
    end

    // Valid bits
    always_comb
    begin
        vld_next[0] = adv[0] ? in_vld : vld_reg[0];
        for (int s = 1; s < NS; s++)
        begin
            vld_next[s] = adv[s] ? vld_reg[s-1] : vld_reg[s];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // Payload stages
    always_ff @(posedge clk)
    begin
        for (int s = 0; s < NS; s++)
        begin
            if (adv[s])
            begin
                rem_reg[s] <= rem_next[s];
                lo_reg[s]  <= lo_next[s];
                q_reg[s]   <= q_next[s];
                ovf_reg[s] <= ovf_next[s];
                neg_reg[s] <= neg_next[s];
                w_reg[s]   <= w_next[s];
                inv_reg[s] <= inv_next[s];
            end
        end
    end

    assign vld       = vld_reg;
    assign quo.invis = inv_reg[NS-1];
    assign quo.neg   = neg_reg[NS-1];
    assign quo.ovf   = ovf_reg[NS-1];
    assign quo.quo   = q_reg[NS-1];

endmodule

[rtl/core/ppb_map.sv]
// Viewport mapping, box geometry and the output register.
module ppb_map #(
    parameter int FRAC_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [ppb_pkg::MAP_STAGES-1:0]    adv,
    input  logic                              in_vld,
    input  ppb_pkg::quo_t                     quo,
    input  logic [13:0]                       screen_width,
    input  logic [13:0]                       screen_height,
    output logic [ppb_pkg::MAP_STAGES-1:0]    vld,
    output logic                              visible,
    output logic signed [31:0]                screen_x,
    output logic signed [31:0]                screen_y,
    output logic signed [31:0]                box_left,
    output logic signed [31:0]                box_top,
    output logic signed [31:0]                box_width,
    output logic signed [31:0]                box_height
);

    localparam logic signed [32:0] ONE33   = 33'sd1 <<< FRAC_BITS;
    localparam logic signed [33:0] ONE34   = 34'sd1 <<< FRAC_BITS;
    localparam logic [31:0]        NEG_ONE = ~((32'd1 << FRAC_BITS) - 32'd1);

    logic [ppb_pkg::MAP_STAGES-1:0] vld_reg;
    logic [ppb_pkg::MAP_STAGES-1:0] vld_next;
    logic [ppb_pkg::MAP_STAGES-2:0] inv_reg;

    // stage 1
    logic signed [32:0] t_next [4];
    logic signed [32:0] t_reg  [4];
    // stage 2
    logic signed [47:0] px;
    logic signed [48:0] pr [3];
    logic signed [31:0] sx2_reg, sy2_reg, r12_reg, r22_reg;
    // stage 3
    logic signed [32:0] dr;
    logic signed [33:0] ad;
    logic signed [31:0] sx3_reg, sy3_reg, r13_reg, h3_reg;
    // stage 4
    logic [64:0]        bw_prod;
    logic signed [31:0] sx4_reg, sy4_reg, top4_reg, h4_reg, bw4_reg;
    // stage 5
    logic signed [31:0] left_next;
    logic               visible_reg;
    logic signed [31:0] sx_reg, sy_reg, left_reg, top_reg, bw_reg, h_reg;

    // Signed quotient, saturated, then half-step
    always_comb
    begin
        logic signed [33:0] sv;
        logic signed [31:0] ndc;
        for (int i = 0; i < 4; i++)
        begin
            sv = $signed({1'b0, quo.ovf[i], quo.quo[i]});
            if (quo.neg[i])
            begin
                sv = -sv;
            end
            ndc       = ppb_pkg::sat32(80'(sv));
            t_next[i] = (33'(ndc) + ONE33) >>> 1;
        end
    end

    // Scale to pixels; rows are flipped
    always_comb
    begin
        logic signed [33:0] u;
        px = t_reg[0] * $signed({1'b0, screen_width});
        for (int i = 0; i < 3; i++)
        begin
            u     = ONE34 - 34'(t_reg[i+1]);
            pr[i] = u * $signed({1'b0, screen_height});
        end
    end

    // Box height
    always_comb
    begin
        dr = 33'(r12_reg) - 33'(r22_reg);
        ad = dr[32] ? -34'(dr) : 34'(dr);
    end

    // Box width, rounded half up
    assign bw_prod = 65'({32'd0, h3_reg} * {32'd0, ppb_pkg::WIDTH_K}) + 65'h80000000;

    // Left edge
    assign left_next = ppb_pkg::sat32(80'(33'(sx4_reg) - 33'(bw4_reg >>> 1)));

    // Valid bits
    always_comb
    begin
        vld_next[0] = adv[0] ? in_vld : vld_reg[0];
        for (int s = 1; s < ppb_pkg::MAP_STAGES; s++)
        begin
            vld_next[s] = adv[s] ? vld_reg[s-1] : vld_reg[s];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // Payload stages
    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            t_reg      <= t_next;
            inv_reg[0] <= quo.invis;
        end
        if (adv[1])
        begin
            sx2_reg    <= ppb_pkg::sat32(80'(px));
            sy2_reg    <= ppb_pkg::sat32(80'(pr[0]));
            r12_reg    <= ppb_pkg::sat32(80'(pr[1]));
            r22_reg    <= ppb_pkg::sat32(80'(pr[2]));
            inv_reg[1] <= inv_reg[0];
        end
        if (adv[2])
        begin
            sx3_reg    <= sx2_reg;
            sy3_reg    <= sy2_reg;
            r13_reg    <= r12_reg;
            h3_reg     <= ppb_pkg::sat32(80'(ad));
            inv_reg[2] <= inv_reg[1];
        end
        if (adv[3])
        begin
            sx4_reg    <= sx3_reg;
            sy4_reg    <= sy3_reg;
            h4_reg     <= h3_reg;
            bw4_reg    <= bw_prod[63:32];
            top4_reg   <= ppb_pkg::sat32(80'(33'(r13_reg) - 33'(h3_reg)));
            inv_reg[3] <= inv_reg[2];
        end
        if (adv[4])
        begin
            if (inv_reg[3])
            begin
                visible_reg <= 1'b0;
                sx_reg      <= NEG_ONE;
                sy_reg      <= NEG_ONE;
                left_reg    <= NEG_ONE;
                top_reg     <= NEG_ONE;
                bw_reg      <= NEG_ONE;
                h_reg       <= NEG_ONE;
            end
            else
            begin
                visible_reg <= 1'b1;
                sx_reg      <= sx4_reg;
                sy_reg      <= sy4_reg;
                left_reg    <= left_next;
                top_reg     <= top4_reg;
                bw_reg      <= bw4_reg;
                h_reg       <= h4_reg;
            end
        end
    end

    assign vld        = vld_reg;
    assign visible    = visible_reg;
    assign screen_x   = sx_reg;
    assign screen_y   = sy_reg;
    assign box_left   = left_reg;
    assign box_top    = top_reg;
    assign box_width  = bw_reg;
    assign box_height = h_reg;

endmodule

[rtl/core/perspective_project_box_top.sv]
// Throughput: one item per cycle while out_ready does not stall the pipeline.
// Load items write a coefficient (index below twelve) and give no result.
// The depth is set by the divider, two quotient bits per stage over 16 stages.
// Each stage holds its item only while the stage after it is full and stalled.
// Reset (rst_n low, asynchronous) empties the pipeline, zeroes all twelve coefficients
// and sets the viewport to 1920 x 1080 with both box offsets at zero.
module perspective_project_box_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               kind,
    input  logic [3:0]         coeff_index,
    input  logic signed [31:0] coeff_value,
    input  logic signed [31:0] world_x,
    input  logic signed [31:0] world_y,
    input  logic signed [31:0] world_z,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               visible,
    output logic signed [31:0] screen_x,
    output logic signed [31:0] screen_y,
    output logic signed [31:0] box_left,
    output logic signed [31:0] box_top,
    output logic signed [31:0] box_width,
    output logic signed [31:0] box_height,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    localparam int DOT0 = 0;
    localparam int DIV0 = ppb_pkg::DOT_STAGES;
    localparam int MAP0 = ppb_pkg::DOT_STAGES + ppb_pkg::DIV_STAGES;
    localparam int NS   = ppb_pkg::NUM_STAGES;
    localparam logic [31:0] NEG_ONE = ~((32'd1 << FRAC_BITS) - 32'd1);

    logic [13:0]        width_reg;
    logic [13:0]        height_reg;
    logic signed [31:0] off1_reg;
    logic signed [31:0] off2_reg;

    logic [NS-1:0]  vld_all;
    logic [NS-1:0]  en;
    logic           accept;
    logic           load_we;
    logic           proj_in;

    ppb_pkg::clip_t clip;
    ppb_pkg::quo_t  quo;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 14'd1920;
            height_reg <= 14'd1080;
            off1_reg   <= '0;
            off2_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (ppb_pkg::cfg_idx_t'(cfg_index))
                ppb_pkg::CFG_SCREEN_WIDTH:  width_reg  <= cfg_data[13:0];
                ppb_pkg::CFG_SCREEN_HEIGHT: height_reg <= cfg_data[13:0];
                ppb_pkg::CFG_FIRST_OFFSET:  off1_reg   <= cfg_data;
                ppb_pkg::CFG_SECOND_OFFSET: off2_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Per-stage advance: a stage moves when empty or when the next one moves
    assign en[NS-1] = ~vld_all[NS-1] | out_ready;
    generate
        for (genvar k = 0; k < NS - 1; k++)
        begin : g_adv
            assign en[k] = ~vld_all[k] | en[k+1];
        end
    endgenerate

    // Input item split by kind
    assign in_ready = en[0];
    assign accept   = in_valid && in_ready;
    assign load_we  = accept && (kind == ppb_pkg::KIND_LOAD);
    assign proj_in  = accept && (kind == ppb_pkg::KIND_PROJECT);

    ppb_dot #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dot (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (en[DIV0-1:DOT0]),
        .load_we     (load_we),
        .coeff_index (coeff_index),
        .coeff_value (coeff_value),
        .proj_in     (proj_in),
        .world_x     (world_x),
        .world_y     (world_y),
        .world_z     (world_z),
        .off_first   (off1_reg),
        .off_second  (off2_reg),
        .vld         (vld_all[DIV0-1:DOT0]),
        .clip        (clip)
    );

    ppb_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .adv    (en[MAP0-1:DIV0]),
        .in_vld (vld_all[DIV0-1]),
        .clip   (clip),
        .vld    (vld_all[MAP0-1:DIV0]),
        .quo    (quo)
    );

    ppb_map #(
        .FRAC_BITS (FRAC_BITS)
    ) u_map (
        .clk           (clk),
        .rst_n         (rst_n),
        .adv           (en[NS-1:MAP0]),
        .in_vld        (vld_all[MAP0-1]),
        .quo           (quo),
        .screen_width  (width_reg),
        .screen_height (height_reg),
        .vld           (vld_all[NS-1:MAP0]),
        .visible       (visible),
        .screen_x      (screen_x),
        .screen_y      (screen_y),
        .box_left      (box_left),
        .box_top       (box_top),
        .box_width     (box_width),
        .box_height    (box_height)
    );

    assign out_valid = vld_all[NS-1];

`ifndef SYNTHESIS
    // Hidden points carry -1.0 in every coordinate
    a_invis_fill: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !visible |-> (screen_x == NEG_ONE) && (box_left == NEG_ONE)
            && (box_width == NEG_ONE) && (box_height == NEG_ONE))
        else $error("hidden point not filled with -1.0");

    // Height is a magnitude
    a_height_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && visible |-> !box_height[31])
        else $error("negative box height");

    // Width is a fraction of the height
    a_width_le: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && visible |-> !box_width[31] && (box_width <= box_height))
        else $error("box width exceeds height");

    // A load item never starts a result
    a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        load_we && !vld_all[DOT0] |=> !vld_all[DOT0])
        else $error("load item entered the pipeline");
`endif

endmodule

[test/perspective_project_box_top_test.sv]
// Self-checking testbench for the perspective projection box unit.
module perspective_project_box_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB = 16;
    localparam longint ONE = 64'sd1 << FB;
    localparam int LIMIT = 400000;

    logic clk, rst_n;
    logic in_valid, in_ready, kind;
    logic [3:0] coeff_index;
    logic signed [31:0] coeff_value, world_x, world_y, world_z;
    logic out_valid, out_ready, visible;
    logic signed [31:0] screen_x, screen_y, box_left, box_top, box_width, box_height;
    logic cfg_valid, cfg_ready;
    logic [1:0] cfg_index;
    logic [31:0] cfg_data;

    perspective_project_box_top dut (.*);

    typedef struct packed {
        logic vis;
        logic [5:0][31:0] f;
    } proj_t;

    // predictor state
    longint coef [ppb_pkg::NUM_COEF];
    longint scr_w, scr_h, off1, off2;
    proj_t expected_q[$];
    int errors, cycles;
    int send_idle, recv_idle;

    initial begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // run limit
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic longint sat(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint fl_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint dot(int row, longint x, longint y, longint z);
        return sat(fl_shift(coef[row*4]*x, FB) + fl_shift(coef[row*4+1]*y, FB)
                   + fl_shift(coef[row*4+2]*z, FB) + coef[row*4+3]);
    endfunction

    function automatic longint half_step(longint v, longint w);
        longint ndc;
        ndc = sat((v * ONE) / w);
        return fl_shift(ndc + ONE, 1);
    endfunction

    function automatic longint screen_row(longint v, longint w);
        return sat((ONE - half_step(v, w)) * scr_h);
    endfunction

    function automatic proj_t project_point(longint x, longint y, longint z);
        proj_t r;
        longint w, sx, sy, r1, r2, h, bw, left, top;
        w = dot(2, x, y, z);
        if (w <= 0) begin
            r.vis = 1'b0;
            for (int i = 0; i < 6; i++) r.f[i] = 32'hFFFF0000;
            return r;
        end
        sx = sat(half_step(dot(0, x, y, z), w) * scr_w);
        sy = screen_row(dot(1, x, y, z), w);
        r1 = screen_row(dot(1, x, y, sat(z + off1)), w);
        r2 = screen_row(dot(1, x, y, sat(z + off2)), w);
        h = r1 - r2;
        if (h < 0) h = -h;
        h = sat(h);
        bw = longint'((64'(h) * 64'd2261365357 + 64'h80000000) >> 32);
        left = sat(sx - (bw >>> 1));
        top = sat(r1 - h);
        r.vis = 1'b1;
        r.f[0] = sx[31:0];
        r.f[1] = sy[31:0];
        r.f[2] = left[31:0];
        r.f[3] = top[31:0];
        r.f[4] = bw[31:0];
        r.f[5] = h[31:0];
        return r;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        errors++;
    endtask

    // result checker and receiver stalls
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && out_ready) begin
                if (expected_q.size() == 0) begin
                    report("unexpected result", 0, 0);
                end
                else begin
                    proj_t e;
                    e = expected_q.pop_front();
                    if (visible !== e.vis) report("visible", visible, e.vis);
                    if (screen_x !== e.f[0]) report("screen_x", screen_x, e.f[0]);
                    if (screen_y !== e.f[1]) report("screen_y", screen_y, e.f[1]);
                    if (box_left !== e.f[2]) report("box_left", box_left, e.f[2]);
                    if (box_top !== e.f[3]) report("box_top", box_top, e.f[3]);
                    if (box_width !== e.f[4]) report("box_width", box_width, e.f[4]);
                    if (box_height !== e.f[5]) report("box_height", box_height, e.f[5]);
                end
            end
            out_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // send one item, predicting its result on acceptance; valid drops only
    // while the sender idles or stops
    task automatic send_item(logic k, logic [3:0] idx, logic [31:0] val,
                             logic [31:0] x, logic [31:0] y, logic [31:0] z);
        while ($urandom_range(99) < send_idle) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= k;
        coeff_index <= idx;
        coeff_value <= val;
        world_x <= x;
        world_y <= y;
        world_z <= z;
        do @(posedge clk); while (!in_ready);
        if (k == ppb_pkg::KIND_LOAD) begin
            if (idx < ppb_pkg::NUM_COEF) coef[idx] = longint'(signed'(val));
        end
        else begin
            expected_q.push_back(project_point(longint'(signed'(x)),
                longint'(signed'(y)), longint'(signed'(z))));
        end
    endtask

    task automatic load_coef(int idx, logic [31:0] val);
        send_item(ppb_pkg::KIND_LOAD, idx[3:0], val, $urandom, $urandom, $urandom);
    endtask

    task automatic project(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        send_item(ppb_pkg::KIND_PROJECT, 4'($urandom), $urandom, x, y, z);
    endtask

    // stop sending, wait for the pipeline to drain, then the latency margin
    task automatic drain();
        in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic write_reg(ppb_pkg::cfg_idx_t idx, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            ppb_pkg::CFG_SCREEN_WIDTH:  scr_w = data[13:0];
            ppb_pkg::CFG_SCREEN_HEIGHT: scr_h = data[13:0];
            ppb_pkg::CFG_FIRST_OFFSET:  off1 = longint'(signed'(data));
            default:                    off2 = longint'(signed'(data));
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // a plain camera-like matrix so most points are visible
    task automatic load_camera();
        for (int i = 0; i < ppb_pkg::NUM_COEF; i++) begin
            logic [31:0] v;
            v = 32'($urandom_range(32'(2 * ONE))) - 32'(ONE);
            if (i == 10) v = $urandom_range(32'(ONE), 32'(ONE / 8));
            if (i == 11) v = $urandom_range(32'(8 * ONE), 32'(ONE));
            load_coef(i, v);
        end
    endtask

    function automatic logic [31:0] small_val();
        return 32'($urandom_range(32'(40 * ONE))) - 32'(20 * ONE);
    endfunction

    task automatic test_directed();
        // all coefficients zero: w = 0, invisible
        project(32'h7FFFFFFF, 32'h80000000, 0);
        load_coef(11, 32'(ONE));
        load_coef(10, 32'h7FFFFFFF);
        load_coef(0, 32'h80000000);
        load_coef(5, 32'h7FFFFFFF);
        load_coef(12, 32'(ONE));
        load_coef(15, 32'hFFFFFFFF);
        project(0, 0, 0);
        project(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
        project(32'h80000000, 32'h80000000, 32'h80000000);
        project(32'hFFFFFFFF, 32'h00000001, 32'h80000000);
        load_coef(11, 32'h80000000);
        project(1, 2, 3);
        load_camera();
        project(32'(ONE), 32'(ONE), 32'(5 * ONE));
        project(32'hFFFFFFFF, 32'h7FFFFFFF, 32'(ONE));
    endtask

    task automatic test_random(int n);
        for (int i = 0; i < n; i++) begin
            int r;
            r = $urandom_range(99);
            if (r < 5) load_coef($urandom_range(15), $urandom);
            else if (r < 8) load_camera();
            else if (r < 80) project(small_val(), small_val(), small_val());
            else project($urandom, $urandom, $urandom);
        end
    endtask

    task automatic test_config(int w, int h, logic [31:0] o1, logic [31:0] o2, int n);
        drain();
        write_reg(ppb_pkg::CFG_SCREEN_WIDTH, w);
        write_reg(ppb_pkg::CFG_SCREEN_HEIGHT, h);
        write_reg(ppb_pkg::CFG_FIRST_OFFSET, o1);
        write_reg(ppb_pkg::CFG_SECOND_OFFSET, o2);
        test_random(n);
    endtask

    task automatic test_pause();
        test_random(20);
        in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
        test_random(20);
    endtask

    initial begin
        rst_n = 0;
        in_valid = 0; kind = 0; coeff_index = 0; coeff_value = 0;
        world_x = 0; world_y = 0; world_z = 0;
        out_ready = 0; cfg_valid = 0; cfg_index = 0; cfg_data = 0;
        errors = 0; cycles = 0;
        send_idle = 26; recv_idle = 55;
        for (int i = 0; i < ppb_pkg::NUM_COEF; i++) coef[i] = 0;
        scr_w = 1920; scr_h = 1080; off1 = 0; off2 = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(150);
        test_pause();
        send_idle = 55; recv_idle = 26;
        test_config(8192, 8192, 32'(2 * ONE), 32'(-2 * ONE), 100);
        test_config(1, 1, 32'h7FFFFFFF, 32'h80000000, 100);
        send_idle = 0; recv_idle = 0;
        test_config(0, 0, 32'(ONE / 2), 32'(3 * ONE), 100);
        test_config(16383, 640, 32'h80000000, 32'h7FFFFFFF, 100);
        test_config(1920, 1080, 0, 32'(ONE), 100);
        drain();

        if (errors == 0) $display("ALL CHECKS PASSED");
        else $display("CHECKS FAILED");
        $finish;
    end
endmodule

[files.f]
rtl/core/ppb_pkg.sv
rtl/core/ppb_dot.sv
rtl/core/ppb_div.sv
rtl/core/ppb_map.sv
rtl/core/perspective_project_box_top.sv
test/perspective_project_box_top_test.sv
